// ===== rtl/cah_pkg.sv =====
// Types, constants and helper functions shared by the coin age histogram.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cah_pkg;

  // Field widths.
  localparam int TIP_W = 31;
  localparam int AGE_W = 38;
  localparam int AMT_W = 51;
  localparam int SUM_W = 63;
  localparam int CNT_W = 32;
  localparam int NBINS = 10;
  localparam int BIN_W = 4;

  // Chain spacing constants.
  localparam logic [TIP_W-1:0] SPLIT_HEIGHT = 31'd707000;
  localparam logic [AGE_W-1:0] SLOW_SPACING = 38'd150;
  localparam logic [AGE_W-1:0] FAST_SPACING = 38'd75;
  localparam logic [AGE_W-1:0] YEAR_SECONDS = 38'd31557600;

  // Exclusive upper bounds of buckets 0 to 8; older ages go to the last bucket.
  localparam logic [AGE_W-1:0] BIN_LIMIT [NBINS-1] = '{
    38'd86400, 38'd604800, 38'd2592000, 38'd7776000, 38'd15552000,
    38'd31557600, 38'd63115200, 38'd94672800, 38'd157788000
  };

  // Result kinds.
  localparam logic [1:0] KIND_ROW     = 2'd0;
  localparam logic [1:0] KIND_BUCKET  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_ROW,
    BK_READ,
    BK_EMIT,
    BK_SUM
  } back_state_t;

  // One classified row as it travels from the front end to the back end.
  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [BIN_W-1:0] bucket;
    logic             keep;
    logic             reject;
    logic             aged;
    logic [AMT_W-1:0] amount;
    logic             eos;
    logic             not_ready;
  } work_t;

  // One bucket entry of the histogram memory.
  typedef struct packed {
    logic [SUM_W-1:0] amount;
    logic [CNT_W-1:0] count;
  } bin_t;

  // One result request as it leaves the block.
  typedef struct packed {
    logic [1:0]       kind;
    logic [BIN_W-1:0] bucket;
    logic [AGE_W-1:0] coin_age;
    logic             row_dropped;
    logic [SUM_W-1:0] amount_sum;
    logic [CNT_W-1:0] item_count;
    logic [SUM_W-1:0] old_amount_sum;
    logic [CNT_W-1:0] old_item_count;
    logic [CNT_W-1:0] dropped_rows;
    logic             tip_not_ready;
    logic             last_item;
  } res_t;

  // Bucket of an age: independent compares against the fixed bounds.
  function automatic logic [BIN_W-1:0] bucket_of(input logic [AGE_W-1:0] age);
    logic [BIN_W-1:0] b;
    b = BIN_W'(NBINS - 1);
    for (int i = NBINS - 2; i >= 0; i--) begin
      if (age < BIN_LIMIT[i]) begin
        b = BIN_W'(i);
      end
    end
    return b;
  endfunction

  // Saturating add of a row amount into a 63-bit sum.
  function automatic logic [SUM_W-1:0] sat_amount(input logic [SUM_W-1:0] a,
                                                  input logic [AMT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // Saturating increment of a 32-bit count.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(1);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/cah_front.sv =====
// Front end: holds the tip register, validates each row and computes its age.
// Depends on cah_pkg; feeds classified rows into cah_queue.
`timescale 1ns / 1ps

module cah_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cah_pkg::TIP_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_row_height,
  input  logic signed [51:0]          in_row_value,
  input  logic                        in_end_of_scan,
  output logic                        push_valid,
  output cah_pkg::work_t              push_rec,
  input  logic                        q_full
);
  import cah_pkg::*;

  logic [TIP_W-1:0] tip_r;
  logic             f_valid_r, f_valid_nxt;
  logic [AGE_W-1:0] f_age_r;
  logic             f_keep_r, f_reject_r, f_eos_r, f_not_ready_r;
  logic [AMT_W-1:0] f_amount_r;

  logic             accept;
  logic [TIP_W-1:0] hu;
  logic             not_ready, bad, keep, reject;
  logic [19:0]      slow_span;
  logic [TIP_W-1:0] fast_base, fast_span;
  logic [AGE_W-1:0] age_full, age;

  // The tip register takes every write request.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tip_r <= '0;
    end else if (cfg_valid) begin
      tip_r <= cfg_data;
    end
  end

  // Row checks against the tip.
  always_comb begin
    hu        = in_row_height[TIP_W-1:0];
    not_ready = (tip_r == '0);
    bad       = in_row_height[31] || (hu > tip_r) || in_row_value[51] ||
                (in_row_value == '0);
    keep      = !not_ready && !bad;
    reject    = !not_ready && bad;
  end

  // Age: slow blocks below the split height, fast blocks from it up to the tip.
  always_comb begin
    slow_span = (hu < SPLIT_HEIGHT) ? (SPLIT_HEIGHT[19:0] - hu[19:0]) : '0;
    fast_base = (hu < SPLIT_HEIGHT) ? SPLIT_HEIGHT : hu;
    fast_span = (tip_r > fast_base) ? (tip_r - fast_base) : '0;
    age_full  = AGE_W'(slow_span) * SLOW_SPACING + AGE_W'(fast_span) * FAST_SPACING;
    age       = keep ? age_full : '0;
  end

  // Single holding register ahead of the queue.
  assign in_stall   = f_valid_r && q_full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = f_valid_r && !q_full;

  always_comb begin
    f_valid_nxt = accept ? 1'b1 : (f_valid_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_age_r       <= age;
      f_keep_r      <= keep;
      f_reject_r    <= reject;
      f_amount_r    <= in_row_value[AMT_W-1:0];
      f_eos_r       <= in_end_of_scan;
      f_not_ready_r <= not_ready;
    end
  end

  // Bucket and one-year flag are resolved on the way into the queue.
  always_comb begin
    push_rec.age       = f_age_r;
    push_rec.bucket    = bucket_of(f_age_r);
    push_rec.keep      = f_keep_r;
    push_rec.reject    = f_reject_r;
    push_rec.aged      = f_keep_r && (f_age_r >= YEAR_SECONDS);
    push_rec.amount    = f_amount_r;
    push_rec.eos       = f_eos_r;
    push_rec.not_ready = f_not_ready_r;
  end

endmodule

// ===== rtl/cah_queue.sv =====
// Short first-in first-out queue of classified rows between front and back end.
// Depends on cah_pkg for the row record type.
`timescale 1ns / 1ps

module cah_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  cah_pkg::work_t push_rec,
  output logic           q_full,
  input  logic           pop,
  output logic           q_valid,
  output cah_pkg::work_t q_rec
);
  import cah_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  work_t              slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] fill_r, fill_nxt;

  assign q_full  = (fill_r == CNT_W_Q'(DEPTH));
  assign q_valid = (fill_r != '0);
  assign q_rec   = slots_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_valid && !pop) begin
      fill_nxt = fill_r + CNT_W_Q'(1);
    end else if (pop && !push_valid) begin
      fill_nxt = fill_r - CNT_W_Q'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== rtl/cah_back.sv =====
// Back end: bucket read-modify-write, running totals and the report sequencer.
// Depends on cah_pkg; drains cah_queue and drives the output register.
`timescale 1ns / 1ps

module cah_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  cah_pkg::work_t q_rec,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output cah_pkg::res_t  out_res
);
  import cah_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [BIN_W-1:0] k_r, k_nxt;

  // Bucket memory with per-entry valid bits so reset reads as zero.
  bin_t             bins_mem [NBINS];
  logic [NBINS-1:0] bin_ok_r;
  bin_t             rd_r;

  logic             y_valid_r;
  work_t            y_rec_r;
  logic             nr_r;

  logic [SUM_W-1:0] grand_amt_r, aged_amt_r;
  logic [CNT_W-1:0] grand_cnt_r, aged_cnt_r, rej_cnt_r;

  logic             out_valid_r;
  res_t             out_res_r, out_res_nxt;

  logic             out_free, y_adv, out_load, clear_totals;
  logic             wen, ren;
  logic [BIN_W-1:0] waddr, raddr;
  bin_t             wdata;

  assign out_free = !out_valid_r || !out_stall;

  // Next state of the report sequencer.
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      BK_ROW: begin
        if (y_valid_r && out_free && y_rec_r.eos) begin
          state_nxt = BK_READ;
          k_nxt     = '0;
        end
      end
      BK_READ: begin
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          if (k_r == BIN_W'(NBINS - 1)) begin
            state_nxt = BK_SUM;
          end else begin
            state_nxt = BK_READ;
            k_nxt     = k_r + BIN_W'(1);
          end
        end
      end
      BK_SUM: begin
        if (out_free) begin
          state_nxt = BK_ROW;
        end
      end
      default: begin
        state_nxt = BK_ROW;
      end
    endcase
  end

  // Pipeline control, memory ports and the result request for each state.
  always_comb begin
    y_adv        = 1'b0;
    q_pop        = 1'b0;
    wen          = 1'b0;
    waddr        = y_rec_r.bucket;
    wdata        = '0;
    ren          = 1'b0;
    raddr        = q_rec.bucket;
    out_load     = 1'b0;
    clear_totals = 1'b0;
    out_res_nxt  = '0;
    unique case (state_r)
      BK_ROW: begin
        y_adv = y_valid_r && out_free;
        q_pop = q_valid && (!y_valid_r || (y_adv && !y_rec_r.eos));
        ren   = q_pop;
        wen   = y_adv && y_rec_r.keep;
        wdata.amount = sat_amount(rd_r.amount, y_rec_r.amount);
        wdata.count  = sat_inc(rd_r.count);
        out_load = y_adv;
        out_res_nxt.kind        = KIND_ROW;
        out_res_nxt.bucket      = y_rec_r.bucket;
        out_res_nxt.coin_age    = y_rec_r.age;
        out_res_nxt.row_dropped = !y_rec_r.keep;
        out_res_nxt.last_item   = !y_rec_r.eos;
      end
      BK_READ: begin
        ren   = 1'b1;
        raddr = k_r;
      end
      BK_EMIT: begin
        out_load = out_free;
        wen      = out_free;
        waddr    = k_r;
        out_res_nxt.kind       = KIND_BUCKET;
        out_res_nxt.bucket     = k_r;
        out_res_nxt.amount_sum = rd_r.amount;
        out_res_nxt.item_count = rd_r.count;
      end
      BK_SUM: begin
        out_load     = out_free;
        clear_totals = out_free;
        out_res_nxt.kind           = KIND_SUMMARY;
        out_res_nxt.amount_sum     = grand_amt_r;
        out_res_nxt.item_count     = grand_cnt_r;
        out_res_nxt.old_amount_sum = aged_amt_r;
        out_res_nxt.old_item_count = aged_cnt_r;
        out_res_nxt.dropped_rows   = rej_cnt_r;
        out_res_nxt.tip_not_ready  = nr_r;
        out_res_nxt.last_item      = 1'b1;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_ROW;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // Bucket memory: one write port, one registered read port with forwarding.
  always_ff @(posedge clk) begin
    if (wen) begin
      bins_mem[waddr] <= wdata;
    end
    if (ren) begin
      if (wen && (waddr == raddr)) begin
        rd_r <= wdata;
      end else begin
        rd_r <= bin_ok_r[raddr] ? bins_mem[raddr] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_ok_r <= '0;
    end else if (wen) begin
      bin_ok_r[waddr] <= 1'b1;
    end
  end

  // Update stage holding the row whose bucket is being read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_valid_r <= 1'b0;
    end else if (q_pop) begin
      y_valid_r <= 1'b1;
    end else if (y_adv) begin
      y_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      y_rec_r <= q_rec;
    end
    if (y_adv && y_rec_r.eos) begin
      nr_r <= y_rec_r.not_ready;
    end
  end

  // Running totals, cleared once the summary is sent.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_totals) begin
      grand_amt_r <= '0;
      grand_cnt_r <= '0;
      aged_amt_r  <= '0;
      aged_cnt_r  <= '0;
      rej_cnt_r   <= '0;
    end else if (y_adv) begin
      if (y_rec_r.keep) begin
        grand_amt_r <= sat_amount(grand_amt_r, y_rec_r.amount);
        grand_cnt_r <= sat_inc(grand_cnt_r);
      end
      if (y_rec_r.aged) begin
        aged_amt_r <= sat_amount(aged_amt_r, y_rec_r.amount);
        aged_cnt_r <= sat_inc(aged_cnt_r);
      end
      if (y_rec_r.reject) begin
        rej_cnt_r <= sat_inc(rej_cnt_r);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/coin_age_histogram.sv =====
// Coin age histogram top level. Rows flow at one per cycle, limited by the
// bucket memory port, while out_stall is low and no end of scan report runs.
// A row marked end of scan adds a report (a read and a request per bucket,
// then the summary); rows collect in the queue during it.
// Reset (synchronous, active low) clears the tip to 0, all totals, bucket
// valid bits and control; the bucket memory itself needs no clearing pass.
`timescale 1ns / 1ps

module coin_age_histogram #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cah_pkg::TIP_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_row_height,
  input  logic signed [51:0]          in_row_value,
  input  logic                        in_end_of_scan,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [cah_pkg::BIN_W-1:0]   out_bucket,
  output logic [cah_pkg::AGE_W-1:0]   out_coin_age,
  output logic                        out_row_dropped,
  output logic [cah_pkg::SUM_W-1:0]   out_amount_sum,
  output logic [cah_pkg::CNT_W-1:0]   out_item_count,
  output logic [cah_pkg::SUM_W-1:0]   out_old_amount_sum,
  output logic [cah_pkg::CNT_W-1:0]   out_old_item_count,
  output logic [cah_pkg::CNT_W-1:0]   out_dropped_rows,
  output logic                        out_tip_not_ready,
  output logic                        out_last_item
);
  import cah_pkg::*;

  logic  push_valid, q_full, q_valid, q_pop;
  work_t push_rec, q_rec;
  res_t  res;

  // Row validation and age computation.
  cah_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_row_height  (in_row_height),
    .in_row_value   (in_row_value),
    .in_end_of_scan (in_end_of_scan),
    .push_valid     (push_valid),
    .push_rec       (push_rec),
    .q_full         (q_full)
  );

  // Decoupling queue.
  cah_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_rec   (push_rec),
    .q_full     (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_rec      (q_rec)
  );

  // Accumulation and reporting.
  cah_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // Result fields to ports.
  assign out_kind           = res.kind;
  assign out_bucket         = res.bucket;
  assign out_coin_age       = res.coin_age;
  assign out_row_dropped    = res.row_dropped;
  assign out_amount_sum     = res.amount_sum;
  assign out_item_count     = res.item_count;
  assign out_old_amount_sum = res.old_amount_sum;
  assign out_old_item_count = res.old_item_count;
  assign out_dropped_rows   = res.dropped_rows;
  assign out_tip_not_ready  = res.tip_not_ready;
  assign out_last_item      = res.last_item;

endmodule

// ===== test/tb_coin_age_histogram.sv =====
// Self-checking testbench for coin_age_histogram: directed and random row scans
// against an in-bench predictor, with random stalls on both channels.
// Depends on rtl/cah_pkg.sv and rtl/coin_age_histogram.sv.
`timescale 1ns / 1ps

module tb_coin_age_histogram;
  import cah_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ROWS_PER_PHASE = 34;
  localparam logic [TIP_W-1:0] TIP_MAX = {TIP_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_TOP = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0] AMOUNT_TOP = {SUM_W{1'b1}};
  localparam longint unsigned FORK_HEIGHT = 707000;
  localparam longint unsigned YEAR_SPAN = 31557600;
  localparam longint unsigned AGE_BOUND [9] = '{
    86400, 604800, 2592000, 7776000, 15552000,
    31557600, 63115200, 94672800, 157788000
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [TIP_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic signed [31:0]  in_row_height;
  logic signed [51:0]  in_row_value;
  logic                in_end_of_scan;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_kind;
  logic [BIN_W-1:0]    out_bucket;
  logic [AGE_W-1:0]    out_coin_age;
  logic                out_row_dropped;
  logic [SUM_W-1:0]    out_amount_sum;
  logic [CNT_W-1:0]    out_item_count;
  logic [SUM_W-1:0]    out_old_amount_sum;
  logic [CNT_W-1:0]    out_old_item_count;
  logic [CNT_W-1:0]    out_dropped_rows;
  logic                out_tip_not_ready;
  logic                out_last_item;

  // Predictor copy of the tip and the histogram stores.
  logic [TIP_W-1:0]    model_tip;
  logic [SUM_W-1:0]    bin_amt [NBINS];
  logic [CNT_W-1:0]    bin_cnt [NBINS];
  logic [SUM_W-1:0]    grand_amt;
  logic [CNT_W-1:0]    grand_cnt;
  logic [SUM_W-1:0]    old_amt;
  logic [CNT_W-1:0]    old_cnt;
  logic [CNT_W-1:0]    reject_cnt;
  res_t                expected_q [$];

  int                  errors = 0;
  int                  cycle_count = 0;
  int                  send_calm = 0;
  int                  recv_calm = 0;

  coin_age_histogram u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_row_height      (in_row_height),
    .in_row_value       (in_row_value),
    .in_end_of_scan     (in_end_of_scan),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_bucket         (out_bucket),
    .out_coin_age       (out_coin_age),
    .out_row_dropped    (out_row_dropped),
    .out_amount_sum     (out_amount_sum),
    .out_item_count     (out_item_count),
    .out_old_amount_sum (out_old_amount_sum),
    .out_old_item_count (out_old_item_count),
    .out_dropped_rows   (out_dropped_rows),
    .out_tip_not_ready  (out_tip_not_ready),
    .out_last_item      (out_last_item)
  );

  always #4 clk = ~clk;

  // Saturating accumulate of a positive amount.
  function automatic logic [SUM_W-1:0] add_amount(input logic [SUM_W-1:0] acc,
                                                  input logic [AMT_W-1:0] amt);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(amt);
    return s[SUM_W] ? AMOUNT_TOP : s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  // Seconds since creation: 150 s per block before the fork height, 75 s after.
  function automatic logic [AGE_W-1:0] row_age(input logic [TIP_W-1:0] h,
                                               input logic [TIP_W-1:0] tip);
    longint unsigned hh;
    longint unsigned tt;
    longint unsigned a;
    hh = 64'(h);
    tt = 64'(tip);
    if (hh < FORK_HEIGHT) begin
      a = (FORK_HEIGHT - hh) * 150;
      if (tt > FORK_HEIGHT) a = a + (tt - FORK_HEIGHT) * 75;
    end else begin
      a = (tt >= hh) ? (tt - hh) * 75 : 0;
    end
    return a[AGE_W-1:0];
  endfunction

  function automatic logic [BIN_W-1:0] age_bucket(input logic [AGE_W-1:0] age);
    for (int i = 0; i < NBINS - 1; i++) begin
      if (age < AGE_BOUND[i]) return BIN_W'(i);
    end
    return BIN_W'(NBINS - 1);
  endfunction

  task automatic clear_tally();
    for (int k = 0; k < NBINS; k++) begin
      bin_amt[k] = '0;
      bin_cnt[k] = '0;
    end
    grand_amt = '0;
    grand_cnt = '0;
    old_amt = '0;
    old_cnt = '0;
    reject_cnt = '0;
  endtask

  // Tally one accepted row and queue the results it causes.
  task automatic record_row(input logic signed [31:0] h, input logic signed [51:0] v,
                            input logic eos);
    res_t             r;
    logic [AGE_W-1:0] age;
    logic [BIN_W-1:0] b;
    logic             dropped;
    logic             waiting;
    waiting = (model_tip == '0);
    age = '0;
    b = '0;
    dropped = 1'b1;
    if (!waiting) begin
      if (h[31] || h[30:0] > model_tip || v[51] || v == '0) begin
        reject_cnt = count_up(reject_cnt);
      end else begin
        dropped = 1'b0;
        age = row_age(h[30:0], model_tip);
        b = age_bucket(age);
        bin_amt[b] = add_amount(bin_amt[b], v[AMT_W-1:0]);
        bin_cnt[b] = count_up(bin_cnt[b]);
        grand_amt = add_amount(grand_amt, v[AMT_W-1:0]);
        grand_cnt = count_up(grand_cnt);
        if (age >= YEAR_SPAN) begin
          old_amt = add_amount(old_amt, v[AMT_W-1:0]);
          old_cnt = count_up(old_cnt);
        end
      end
    end
    r = '0;
    r.kind = KIND_ROW;
    r.bucket = b;
    r.coin_age = age;
    r.row_dropped = dropped;
    r.last_item = !eos;
    expected_q.push_back(r);
    if (eos) begin
      for (int k = 0; k < NBINS; k++) begin
        r = '0;
        r.kind = KIND_BUCKET;
        r.bucket = BIN_W'(k);
        r.amount_sum = bin_amt[k];
        r.item_count = bin_cnt[k];
        expected_q.push_back(r);
      end
      r = '0;
      r.kind = KIND_SUMMARY;
      r.amount_sum = grand_amt;
      r.item_count = grand_cnt;
      r.old_amount_sum = old_amt;
      r.old_item_count = old_cnt;
      r.dropped_rows = reject_cnt;
      r.tip_not_ready = waiting;
      r.last_item = 1'b1;
      expected_q.push_back(r);
      clear_tally();
    end
  endtask

  // Send one row request; returns right after the edge that accepts it.
  task automatic send_row(input logic signed [31:0] h, input logic signed [51:0] v,
                          input logic eos);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 5) == 0) send_calm = 16;
      gap = $urandom_range(0, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_row_height = h;
    in_row_value = v;
    in_end_of_scan = eos;
    do @(posedge clk); while (in_stall !== 1'b0);
    record_row(h, v, eos);
  endtask

  // Lower the row valid and wait until every expected result has arrived.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // Write the tip register; only called while the block is idle.
  task automatic write_tip(input logic [TIP_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    model_tip = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // With the tip at zero, every row is ignored and the summary flags it.
  task automatic test_tip_not_ready();
    write_tip('0);
    send_row(32'sd1000, 52'sd5, 1'b0);
    send_row(32'sd0, 52'sd1, 1'b0);
    send_row(-32'sd1, -52'sd1, 1'b1);
    wait_idle();
  endtask

  // Negative height, height past the tip, zero and negative amounts.
  task automatic test_rejected_rows();
    write_tip(31'd1000000);
    send_row(32'sh8000_0000, 52'sd10, 1'b0);
    send_row(-32'sd1, 52'sd10, 1'b0);
    send_row(32'sd1000001, 52'sd10, 1'b0);
    send_row(32'sh7fff_ffff, 52'sd10, 1'b0);
    send_row(32'sd500, 52'sd0, 1'b0);
    send_row(32'sd500, 52'sh8_0000_0000_0000, 1'b0);
    send_row(32'sd500, -52'sd1, 1'b0);
    send_row(32'sd1000000, 52'sd7, 1'b1);
    wait_idle();
  endtask

  // Each row lands exactly on a bucket bound, so it falls in the next bucket.
  task automatic test_bucket_edges();
    logic [TIP_W-1:0] tip;
    tip = 31'd10000000;
    write_tip(tip);
    for (int i = 0; i < NBINS - 1; i++) begin
      send_row(32'(tip - AGE_BOUND[i] / 75), 52'(i + 1), 1'b0);
    end
    send_row(32'(tip), 52'sd3, 1'b1);
    wait_idle();
  endtask

  // Largest tip and amount, heights around the fork, and the smallest tip.
  task automatic test_extremes();
    write_tip(TIP_MAX);
    send_row(32'sd0, 52'sh7_ffff_ffff_ffff, 1'b0);
    send_row(32'sd706999, 52'sh7_ffff_ffff_ffff, 1'b0);
    send_row(32'sd707000, 52'sd1, 1'b0);
    send_row(32'sh7fff_ffff, 52'sd1, 1'b1);
    wait_idle();
    write_tip(31'd1);
    send_row(32'sd0, 52'sd2, 1'b0);
    send_row(32'sd1, 52'sd4, 1'b1);
    wait_idle();
  endtask

  // Random scans under several tips: mostly valid rows, some noise.
  task automatic test_random_scans();
    logic [TIP_W-1:0]   tips [10];
    logic [TIP_W-1:0]   rnd_tip;
    logic signed [31:0] h;
    logic signed [51:0] v;
    logic               eos;
    int unsigned        tip_u;
    int unsigned        span;
    int                 left;
    int                 mode;
    rnd_tip = TIP_W'($urandom);
    tips = '{31'd0, 31'd1, 31'd706999, 31'd707000, 31'd707001, TIP_MAX, rnd_tip,
             31'($urandom_range(707000, 5000000)), 31'($urandom_range(2, 706998)),
             31'($urandom_range(2200000, 30000000))};
    foreach (tips[p]) begin
      write_tip(tips[p]);
      tip_u = 32'(tips[p]);
      span = (tip_u < 2200000) ? tip_u : 2200000;
      left = 0;
      for (int n = 0; n < ROWS_PER_PHASE; n++) begin
        if (left == 0) left = $urandom_range(1, 12);
        left--;
        eos = (left == 0) || (n == ROWS_PER_PHASE - 1);
        // Well-formed row with random content.
        mode = $urandom_range(0, 3);
        case (mode)
          0: h = 32'(tip_u - $urandom_range(0, span));
          1: h = 32'($urandom_range(0, tip_u));
          2: h = 32'($urandom_range(0, (tip_u < 706999) ? tip_u : 706999));
          default: h = 32'(tip_u);
        endcase
        if ($urandom_range(0, 1) == 0) begin
          v = 52'($urandom_range(1, 100000));
        end else begin
          v = {1'b0, 19'($urandom), 32'($urandom)};
          if (v == '0) v = 52'sd1;
        end
        // Noise: fully random fields, height past the tip, or a bad amount.
        if ($urandom_range(0, 4) == 0) begin
          mode = $urandom_range(0, 2);
          case (mode)
            0: begin
              h = $urandom;
              v = {20'($urandom), 32'($urandom)};
            end
            1: h = 32'(tip_u + 1 + $urandom_range(0, 1000));
            default: v = -52'($urandom_range(0, 1000));
          endcase
        end
        send_row(h, v, eos);
      end
      wait_idle();
    end
  endtask

  // Receiver: random stall before each result, with calm stretches.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      if (recv_calm > 0) begin
        recv_calm--;
        n = 0;
      end else begin
        if ($urandom_range(0, 5) == 0) recv_calm = 24;
        n = $urandom_range(0, 3);
      end
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, kind %0d bucket %0d",
                 $time, out_kind, out_bucket);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_kind));
        check_field("bucket", 64'(want.bucket), 64'(out_bucket));
        check_field("coin_age", 64'(want.coin_age), 64'(out_coin_age));
        check_field("row_dropped", 64'(want.row_dropped), 64'(out_row_dropped));
        check_field("amount_sum", 64'(want.amount_sum), 64'(out_amount_sum));
        check_field("item_count", 64'(want.item_count), 64'(out_item_count));
        check_field("old_amount_sum", 64'(want.old_amount_sum),
                    64'(out_old_amount_sum));
        check_field("old_item_count", 64'(want.old_item_count),
                    64'(out_old_item_count));
        check_field("dropped_rows", 64'(want.dropped_rows), 64'(out_dropped_rows));
        check_field("tip_not_ready", 64'(want.tip_not_ready), 64'(out_tip_not_ready));
        check_field("last_item", 64'(want.last_item), 64'(out_last_item));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_row_height = '0;
    in_row_value = '0;
    in_end_of_scan = 1'b0;
    model_tip = '0;
    clear_tally();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_tip_not_ready();
    test_rejected_rows();
    test_bucket_edges();
    test_extremes();
    test_random_scans();

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (expected_q.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, expected_q.size());
      end
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
